// File: rtl/core/usd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the decoder front end, the result queue, the expander and the top level.
package usd_pkg;

  // Code point width and the replacement character
  localparam int unsigned CpW         = 21;
  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  // Byte classification masks and patterns
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] PayMask   = 8'h3F;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Results per byte: 0..4
  localparam int unsigned RunW = 3;

  // One byte's worth of results: count-1 replacement characters, then
  // one final result carrying cp and rep.
  typedef struct packed {
    logic [RunW-1:0] count;
    logic [CpW-1:0]  cp;
    logic            rep;
  } run_desc_t;

  // Queue head as seen by the expander
  typedef struct packed {
    logic      avail;
    run_desc_t desc;
  } q_head_t;

endpackage

// File: rtl/core/usd_front.sv
// Decoder front end: keeps the open-sequence state and turns each byte
// into a result run descriptor. Depends on usd_pkg.
module usd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                end_of_string_i,
  output logic                push_o,
  output usd_pkg::run_desc_t  desc_o
);

  logic [usd_pkg::CpW-1:0] partial_q, partial_d;
  logic [1:0]              needed_q, needed_d;
  logic [1:0]              seen_q, seen_d;

  logic                    is_cont;
  logic                    seq_open;
  logic [1:0]              seen_inc;
  logic [usd_pkg::CpW-1:0] merged;
  logic [usd_pkg::RunW-1:0] base;

  assign is_cont  = (in_byte_i & usd_pkg::ContMask) == usd_pkg::ContPat;
  assign seq_open = needed_q != 2'd0;
  assign seen_inc = seen_q + 2'd1;
  assign merged   = {partial_q[usd_pkg::CpW-7:0], in_byte_i[5:0] & usd_pkg::PayMask[5:0]};
  // Replacements owed for an open sequence: lead byte plus continuations taken
  assign base     = seq_open ? {1'b0, seen_inc} : '0;

  // Classify the byte and build the run of results it causes
  always_comb begin
    partial_d    = partial_q;
    needed_d     = needed_q;
    seen_d       = seen_q;
    desc_o.count = '0;
    desc_o.cp    = usd_pkg::ReplChar;
    desc_o.rep   = 1'b1;

    if (seq_open && is_cont) begin
      if (seen_inc == needed_q) begin
        // Sequence complete: emit the gathered code point
        desc_o.count = usd_pkg::RunW'(1);
        desc_o.cp    = merged;
        desc_o.rep   = 1'b0;
        partial_d    = '0;
        needed_d     = 2'd0;
        seen_d       = 2'd0;
      end else if (end_of_string_i) begin
        // String ends mid-sequence: flush lead and all continuations
        desc_o.count = {1'b0, seen_inc} + usd_pkg::RunW'(1);
        partial_d    = '0;
        needed_d     = 2'd0;
        seen_d       = 2'd0;
      end else begin
        partial_d = merged;
        seen_d    = seen_inc;
      end
    end else begin
      // Close any open sequence, then treat the byte as a new lead
      partial_d = '0;
      needed_d  = 2'd0;
      seen_d    = 2'd0;
      if (!in_byte_i[7]) begin
        desc_o.count = base + usd_pkg::RunW'(1);
        desc_o.cp    = {{(usd_pkg::CpW-8){1'b0}}, in_byte_i};
        desc_o.rep   = 1'b0;
      end else if ((in_byte_i & usd_pkg::Lead2Mask) == usd_pkg::Lead2Pat ||
                   (in_byte_i & usd_pkg::Lead3Mask) == usd_pkg::Lead3Pat ||
                   (in_byte_i & usd_pkg::Lead4Mask) == usd_pkg::Lead4Pat) begin
        if (end_of_string_i) begin
          // New lead at end of string: flushed at once
          desc_o.count = base + usd_pkg::RunW'(1);
        end else begin
          desc_o.count = base;
          seen_d       = 2'd0;
          if ((in_byte_i & usd_pkg::Lead2Mask) == usd_pkg::Lead2Pat) begin
            partial_d = {{(usd_pkg::CpW-5){1'b0}}, in_byte_i[4:0]};
            needed_d  = 2'd1;
          end else if ((in_byte_i & usd_pkg::Lead3Mask) == usd_pkg::Lead3Pat) begin
            partial_d = {{(usd_pkg::CpW-4){1'b0}}, in_byte_i[3:0]};
            needed_d  = 2'd2;
          end else begin
            partial_d = {{(usd_pkg::CpW-3){1'b0}}, in_byte_i[2:0]};
            needed_d  = 2'd3;
          end
        end
      end else begin
        // Stray continuation or invalid lead
        desc_o.count = base + usd_pkg::RunW'(1);
      end
    end
  end

  assign push_o = accept_i && (desc_o.count != '0);

  // Advance the sequence state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      needed_q  <= 2'd0;
      seen_q    <= 2'd0;
    end else if (accept_i) begin
      partial_q <= partial_d;
      needed_q  <= needed_d;
      seen_q    <= seen_d;
    end
  end

endmodule

// File: rtl/core/usd_queue.sv
// Small FIFO of result run descriptors between front end and expander.
// Depends on usd_pkg.
module usd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  usd_pkg::run_desc_t desc_i,
  input  logic               pop_i,
  output usd_pkg::q_head_t   head_o,
  output logic               full_o
);

  usd_pkg::run_desc_t         mem_q [usd_pkg::QDepth];
  logic [usd_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [usd_pkg::QCntW-1:0]  cnt_q;

  assign full_o       = cnt_q == usd_pkg::QCntW'(usd_pkg::QDepth);
  assign head_o.avail = cnt_q != '0;
  assign head_o.desc  = mem_q[rd_ptr_q];

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + usd_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + usd_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + usd_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - usd_pkg::QCntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/usd_back.sv
// Expander: replays each run descriptor as single results into the
// output register. Depends on usd_pkg.
module usd_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  usd_pkg::q_head_t        head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [usd_pkg::CpW-1:0] code_point_o,
  output logic                    was_replaced_o,
  output logic                    last_of_run_o
);

  logic [1:0] sent_q;
  logic       valid_q;
  logic       slot_free;
  logic       fire;
  logic       is_last;

  assign slot_free = !valid_q || !out_stall_i;
  assign fire      = slot_free && head_i.avail;
  assign is_last   = ({1'b0, sent_q} + usd_pkg::RunW'(1)) == head_i.desc.count;
  assign pop_o     = fire && is_last;
  assign out_valid_o = valid_q;

  // Track results sent from the head descriptor, and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (slot_free) begin
        valid_q <= head_i.avail;
      end
      if (fire) begin
        sent_q <= is_last ? 2'd0 : sent_q + 2'd1;
      end
    end
  end

  // Load the output payload; hold it while stalled
  always_ff @(posedge clk_i) begin
    if (fire) begin
      code_point_o   <= is_last ? head_i.desc.cp : usd_pkg::ReplChar;
      was_replaced_o <= is_last ? head_i.desc.rep : 1'b1;
      last_of_run_o  <= is_last;
    end
  end

endmodule

// File: rtl/core/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder with replacement character, top level.
// Depends on usd_pkg, usd_front, usd_queue and usd_back.
//
// Input channel: in_byte_i with end_of_string_i marking the final byte of a
// string, moved by in_valid_i / in_stall_o. Output channel: code_point_o,
// was_replaced_o and last_of_run_o, moved by out_valid_o / out_stall_i.
// A transaction happens on a rising edge with valid high and stall low.
// Each byte yields zero to four results; last_of_run_o marks the final one.
// A result's descriptor is written into the queue at the accepting edge;
// the expander then loads the result into the output register. The input
// takes one byte per cycle while the queue is not full;
// the output register gives one result per cycle while out_stall_i is low,
// so a byte's results leave it one at a time. The four-entry descriptor
// queue absorbs these bursts; in_stall_o rises only when it is full.
// Reset clears the open sequence, the queue and the output valid.
// A stall on the output holds the result in place; the front end keeps
// taking bytes until the queue fills.
module utf8_stream_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        was_replaced_o,
  output logic        last_of_run_o
);

  logic               accept;
  logic               push;
  logic               pop;
  logic               q_full;
  usd_pkg::run_desc_t desc;
  usd_pkg::q_head_t   head;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Classify bytes and track the open sequence
  usd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .push_o          (push),
    .desc_o          (desc)
  );

  // Buffer result runs
  usd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .head_o (head),
    .full_o (q_full)
  );

  // Expand runs into the output register
  usd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .code_point_o   (code_point_o),
    .was_replaced_o (was_replaced_o),
    .last_of_run_o  (last_of_run_o)
  );

  // A decoded (non-replacement) result always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_replaced_o |-> last_of_run_o)
    else $error("decoded result not last of its run");

  // Replacement results carry U+FFFD
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_replaced_o |-> code_point_o == usd_pkg::ReplChar)
    else $error("replacement result with wrong code point");

  // Pop only a present descriptor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.avail)
    else $error("pop from empty queue");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full queue");

endmodule

// File: dv/utf8_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for utf8_stream_decoder_unit: directed and random byte strings,
// with a scoreboard class that predicts the decoded code points.
// Depends on usd_pkg and the utf8_stream_decoder_unit RTL.
module utf8_stream_decoder_unit_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 80;
  localparam int unsigned IdlePercent = 23;
  localparam int unsigned RandBytes   = 145;

  typedef struct {
    logic [usd_pkg::CpW-1:0] cp;
    logic                    rep;
    logic                    last;
  } cp_result_t;

  // Predict decoded code points and check them against the DUT output
  class utf8_scoreboard;
    cp_result_t              expected_cps[$];
    cp_result_t              run_q[$];
    logic [usd_pkg::CpW-1:0] partial_cp;
    logic [1:0]              cont_needed;
    logic [1:0]              cont_seen;
    int unsigned             error_count;

    function new();
      close_seq();
      error_count = 0;
    endfunction

    function void close_seq();
      partial_cp  = '0;
      cont_needed = '0;
      cont_seen   = '0;
    endfunction

    function void add_result(logic [usd_pkg::CpW-1:0] cp, logic rep);
      cp_result_t r;
      r.cp   = cp;
      r.rep  = rep;
      r.last = 1'b0;
      run_q.push_back(r);
    endfunction

    // Replace the lead byte and every continuation byte taken so far
    function void flush_open_seq();
      for (int k = 0; k <= cont_seen; k++) add_result(usd_pkg::ReplChar, 1'b1);
      close_seq();
    endfunction

    function void open_lead(logic [7:0] b);
      if (b[7] == 1'b0) begin
        add_result(usd_pkg::CpW'(b), 1'b0);
      end else if ((b & usd_pkg::Lead2Mask) == usd_pkg::Lead2Pat) begin
        partial_cp  = usd_pkg::CpW'(b[4:0]);
        cont_needed = 2'd1;
        cont_seen   = 2'd0;
      end else if ((b & usd_pkg::Lead3Mask) == usd_pkg::Lead3Pat) begin
        partial_cp  = usd_pkg::CpW'(b[3:0]);
        cont_needed = 2'd2;
        cont_seen   = 2'd0;
      end else if ((b & usd_pkg::Lead4Mask) == usd_pkg::Lead4Pat) begin
        partial_cp  = usd_pkg::CpW'(b[2:0]);
        cont_needed = 2'd3;
        cont_seen   = 2'd0;
      end else begin
        add_result(usd_pkg::ReplChar, 1'b1);
      end
    endfunction

    // Advance the decoder by one accepted byte and queue its results
    function void note_byte(logic [7:0] b, logic eos);
      run_q.delete();
      if (cont_needed != 2'd0) begin
        if ((b & usd_pkg::ContMask) == usd_pkg::ContPat) begin
          partial_cp = {partial_cp[usd_pkg::CpW-7:0], b[5:0]};
          cont_seen  = cont_seen + 2'd1;
          if (cont_seen == cont_needed) begin
            add_result(partial_cp, 1'b0);
            close_seq();
          end
        end else begin
          flush_open_seq();
          open_lead(b);
        end
      end else begin
        open_lead(b);
      end
      if (eos && cont_needed != 2'd0) flush_open_seq();
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) expected_cps.push_back(run_q[i]);
    endfunction

    // Compare one output transaction with the oldest expected result
    function void check_result(logic [usd_pkg::CpW-1:0] cp, logic rep, logic last);
      cp_result_t want;
      if (expected_cps.size() == 0) begin
        error_count++;
        $error("unexpected result: code_point %h was_replaced %b last_of_run %b",
               cp, rep, last);
        return;
      end
      want = expected_cps.pop_front();
      if (cp !== want.cp) begin
        error_count++;
        $error("code_point: expected %h, actual %h", want.cp, cp);
      end
      if (rep !== want.rep) begin
        error_count++;
        $error("was_replaced: expected %b, actual %b", want.rep, rep);
      end
      if (last !== want.last) begin
        error_count++;
        $error("last_of_run: expected %b, actual %b", want.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected_cps.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  in_byte_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [20:0] code_point_o;
  logic        was_replaced_o;
  logic        last_of_run_o;

  utf8_scoreboard sb;
  logic           idle_on  = 1'b1;
  logic           hold_req = 1'b0;
  int unsigned    cycle_count = 0;
  logic [7:0]     str_bytes[$];

  utf8_stream_decoder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_point_o    (code_point_o),
    .was_replaced_o  (was_replaced_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Check every accepted output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(code_point_o, was_replaced_o, last_of_run_o);
  end

  // Stall the output at random; hold it off for a long stretch on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < IdlePercent);
      end
    end
  end

  // Offer one byte, wait for the transaction, then note it; ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (idle_on && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_byte_i       <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, eos);
    @(negedge clk_i);
  endtask

  // Append one character: mostly well formed, some cut short, some raw noise
  task automatic add_char();
    int unsigned kind;
    int unsigned len;
    int unsigned n_cont;
    logic [7:0]  lead;
    kind = $urandom_range(99);
    if (kind >= 85) begin
      str_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    len    = (kind < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
    n_cont = (kind < 70) ? len - 1 : $urandom_range(0, len - 2);
    case (len)
      1: lead = {1'b0, 7'($urandom)};
      2: lead = {3'b110, 5'($urandom)};
      3: lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    str_bytes.push_back(lead);
    repeat (n_cont) str_bytes.push_back({2'b10, 6'($urandom)});
  endtask

  initial begin
    // {end_of_string, byte}
    logic [8:0] dir_seq[$] = '{
      9'h000, 9'h07F, 9'h080, 9'h0BF, 9'h0F8, 9'h0FF,
      9'h0C2, 9'h0A9,
      9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
      9'h0EF, 9'h0BF, 9'h0BD,
      9'h0F0, 9'h090, 9'h080, 9'h1E2,
      9'h0E2, 9'h182,
      9'h0C2, 9'h0FF,
      9'h141
    };
    int unsigned rand_sent;
    int unsigned n_chars;
    logic        hold_done;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_byte_i       = '0;
    end_of_string_i = 1'b0;
    out_stall_i     = 1'b0;
    rand_sent       = 0;
    hold_done       = 1'b0;
    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: byte extremes, each sequence length, breaks and end flushes
    foreach (dir_seq[i]) send_byte(dir_seq[i][7:0], dir_seq[i][8]);

    // Random strings with a quiet stretch and one long output hold-off
    while (rand_sent < RandBytes) begin
      if (!hold_done && rand_sent >= 60) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      idle_on = !(rand_sent >= 100 && rand_sent < 140);
      str_bytes.delete();
      n_chars = $urandom_range(1, 6);
      repeat (n_chars) add_char();
      foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
      rand_sent += str_bytes.size();
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b1;

    // Drain, then allow the pipeline latency to expose stray results
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
